// ===== design/quasi_pr_controller_antiwindup_assert.svh =====
// assertion macros shared by the design files
`ifndef QUASI_PR_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define QUASI_PR_CONTROLLER_ANTIWINDUP_ASSERT_SVH

`ifndef ASSERT_OFF
`define QPR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("qpr assertion failed");
`define QPR_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("qpr forbidden condition seen");
`else
`define QPR_ASSERT(lbl, clk, rstn, prop)
`define QPR_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== design/qpr_pkg.sv =====
`timescale 1ns / 1ps

package qpr_pkg;

    localparam int CoefW      = 32;
    localparam int SampleW    = 16;
    localparam int ErrW       = SampleW + 1;
    localparam int LimitW     = 18;
    localparam int DataW      = 32;
    localparam int AddrW      = 5;
    localparam int RegIdxW    = 3;
    localparam int StepW      = 4;

    localparam int DefCoefFracBits = 24;
    localparam int DefStateWidth   = 48;

    localparam logic [RegIdxW-1:0] REG_B0         = 3'd0;
    localparam logic [RegIdxW-1:0] REG_B1         = 3'd1;
    localparam logic [RegIdxW-1:0] REG_B2         = 3'd2;
    localparam logic [RegIdxW-1:0] REG_A1         = 3'd3;
    localparam logic [RegIdxW-1:0] REG_A2         = 3'd4;
    localparam logic [RegIdxW-1:0] REG_LIMIT_LOW  = 3'd5;
    localparam logic [RegIdxW-1:0] REG_LIMIT_HIGH = 3'd6;
    localparam logic [RegIdxW-1:0] REG_ENABLED    = 3'd7;

    localparam logic signed [LimitW-1:0] LimitLowReset  = -18'sd131072;
    localparam logic signed [LimitW-1:0] LimitHighReset = 18'sd131071;

    localparam logic [StepW-1:0] ADDR_START = 4'd0;
    localparam logic [StepW-1:0] ADDR_FAIL  = 4'd14;
    localparam logic [StepW-1:0] ADDR_CLEAR = 4'd15;

    typedef enum logic [2:0] {
        CSEL_B0, CSEL_B1, CSEL_B2, CSEL_A1, CSEL_A2
    } t_csel;

    typedef enum logic [2:0] {
        OSEL_W1LO, OSEL_W1HI, OSEL_W2LO, OSEL_W2HI, OSEL_W0LO, OSEL_W0HI
    } t_osel;

    typedef enum logic [2:0] {
        AOP_NOP, AOP_LOAD_ERR, AOP_ADD, AOP_SUB, AOP_CLR
    } t_aop;

    typedef enum logic [1:0] {
        CHK_NONE, CHK_W0, CHK_RAW
    } t_chk;

    typedef enum logic [1:0] {
        FIN_NONE, FIN_EMIT_RES, FIN_EMIT_ZERO, FIN_EMIT_CLEAR
    } t_fin;

    typedef struct packed {
        t_csel csel;
        t_osel osel;
        t_aop  aop;
        logic  hi_shift;
        t_chk  chk;
        t_fin  fin;
    } t_uword;

    typedef struct packed {
        logic   run;
        logic   start;
        logic   commit;
        t_uword uw;
    } t_dp_ctl;

    typedef struct packed {
        logic w0_ovf;
        logic raw_ovf;
    } t_dp_stat;

    typedef struct packed {
        logic signed [CoefW-1:0]  b0;
        logic signed [CoefW-1:0]  b1;
        logic signed [CoefW-1:0]  b2;
        logic signed [CoefW-1:0]  a1;
        logic signed [CoefW-1:0]  a2;
        logic signed [LimitW-1:0] limit_low;
        logic signed [LimitW-1:0] limit_high;
    } t_cfg;

    function automatic t_uword uw_make(input t_csel csel, input t_osel osel, input t_aop aop,
                                       input logic hi_shift, input t_chk chk, input t_fin fin);
        t_uword uw;
        uw.csel     = csel;
        uw.osel     = osel;
        uw.aop      = aop;
        uw.hi_shift = hi_shift;
        uw.chk      = chk;
        uw.fin      = fin;
        return uw;
    endfunction

    // hi_shift and aop act on the product registered by the previous step
    function automatic t_uword ucode(input logic [StepW-1:0] step);
        t_uword uw;
        case (step)
            4'd0:  uw = uw_make(CSEL_A1, OSEL_W1LO, AOP_LOAD_ERR, 1'b0, CHK_NONE, FIN_NONE);
            4'd1:  uw = uw_make(CSEL_A1, OSEL_W1HI, AOP_SUB,      1'b0, CHK_NONE, FIN_NONE);
            4'd2:  uw = uw_make(CSEL_A2, OSEL_W2LO, AOP_SUB,      1'b1, CHK_NONE, FIN_NONE);
            4'd3:  uw = uw_make(CSEL_A2, OSEL_W2HI, AOP_SUB,      1'b0, CHK_NONE, FIN_NONE);
            4'd4:  uw = uw_make(CSEL_B0, OSEL_W0LO, AOP_SUB,      1'b1, CHK_NONE, FIN_NONE);
            4'd5:  uw = uw_make(CSEL_B0, OSEL_W0LO, AOP_CLR,      1'b0, CHK_W0,   FIN_NONE);
            4'd6:  uw = uw_make(CSEL_B0, OSEL_W0LO, AOP_NOP,      1'b0, CHK_NONE, FIN_NONE);
            4'd7:  uw = uw_make(CSEL_B0, OSEL_W0HI, AOP_ADD,      1'b0, CHK_NONE, FIN_NONE);
            4'd8:  uw = uw_make(CSEL_B1, OSEL_W1LO, AOP_ADD,      1'b1, CHK_NONE, FIN_NONE);
            4'd9:  uw = uw_make(CSEL_B1, OSEL_W1HI, AOP_ADD,      1'b0, CHK_NONE, FIN_NONE);
            4'd10: uw = uw_make(CSEL_B2, OSEL_W2LO, AOP_ADD,      1'b1, CHK_NONE, FIN_NONE);
            4'd11: uw = uw_make(CSEL_B2, OSEL_W2HI, AOP_ADD,      1'b0, CHK_NONE, FIN_NONE);
            4'd12: uw = uw_make(CSEL_B0, OSEL_W0LO, AOP_ADD,      1'b1, CHK_NONE, FIN_NONE);
            4'd13: uw = uw_make(CSEL_B0, OSEL_W0LO, AOP_NOP,      1'b0, CHK_RAW,  FIN_EMIT_RES);
            4'd14: uw = uw_make(CSEL_B0, OSEL_W0LO, AOP_NOP,      1'b0, CHK_NONE, FIN_EMIT_ZERO);
            4'd15: uw = uw_make(CSEL_B0, OSEL_W0LO, AOP_NOP,      1'b0, CHK_NONE, FIN_EMIT_CLEAR);
            default: uw = uw_make(CSEL_B0, OSEL_W0LO, AOP_NOP,    1'b0, CHK_NONE, FIN_EMIT_ZERO);
        endcase
        return uw;
    endfunction

endpackage

// ===== design/qpr_in_if.sv =====
`timescale 1ns / 1ps

interface qpr_in_if;
    import qpr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [SampleW-1:0] setpoint;
    logic signed [SampleW-1:0] measured;

    modport source (output valid, output req_type, output setpoint, output measured,
                    input ready);
    modport sink   (input valid, input req_type, input setpoint, input measured,
                    output ready);
endinterface

// ===== design/qpr_out_if.sv =====
`timescale 1ns / 1ps

interface qpr_out_if;
    import qpr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [LimitW-1:0] drive;
    logic                     clamped;
    logic                     ok;

    modport source (output valid, output drive, output clamped, output ok, input ready);
    modport sink   (input valid, input drive, input clamped, input ok, output ready);
endinterface

// ===== design/qpr_datapath.sv =====
`timescale 1ns / 1ps
`include "quasi_pr_controller_antiwindup_assert.svh"

module qpr_datapath #(
    parameter int COEF_FRAC_BITS = qpr_pkg::DefCoefFracBits,
    parameter int STATE_WIDTH    = qpr_pkg::DefStateWidth
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  qpr_pkg::t_dp_ctl                        i_ctl,
    input  qpr_pkg::t_cfg                           i_cfg,
    input  logic signed [qpr_pkg::SampleW-1:0]      i_setpoint,
    input  logic signed [qpr_pkg::SampleW-1:0]      i_measured,
    output qpr_pkg::t_dp_stat                       o_stat,
    output logic signed [qpr_pkg::LimitW-1:0]       o_drive,
    output logic                                    o_clamped
);
    import qpr_pkg::*;

    localparam int F     = COEF_FRAC_BITS;
    localparam int SW    = STATE_WIDTH;
    localparam int H     = SW / 2;
    localparam int OpW   = SW - H + 1;
    localparam int ProdW = CoefW + OpW;
    localparam int AccW  = 2 * F + SW + 2;

    logic signed [SW-1:0]    r_d1, r_d2, r_w0;
    logic signed [ErrW-1:0]  r_err;
    logic signed [ProdW-1:0] r_prod;
    logic signed [AccW-1:0]  r_acc;

    logic signed [CoefW-1:0] w_coef;
    logic signed [OpW-1:0]   w_opnd;
    logic signed [AccW-1:0]  w_addend;
    logic signed [SW-1:0]    w_raw;
    logic signed [SW-1:0]    w_lim_hi, w_lim_lo;
    logic                    w_over_hi, w_under_lo, w_freeze;
    logic                    w_err_pos, w_err_neg;

    always_comb begin
        case (i_ctl.uw.csel)
            CSEL_B0: w_coef = i_cfg.b0;
            CSEL_B1: w_coef = i_cfg.b1;
            CSEL_B2: w_coef = i_cfg.b2;
            CSEL_A1: w_coef = i_cfg.a1;
            CSEL_A2: w_coef = i_cfg.a2;
            default: w_coef = i_cfg.b0;
        endcase
    end

    // low halves are unsigned, high halves carry the sign
    always_comb begin
        case (i_ctl.uw.osel)
            OSEL_W1LO: w_opnd = OpW'($signed({1'b0, r_d1[H-1:0]}));
            OSEL_W1HI: w_opnd = OpW'($signed(r_d1[SW-1:H]));
            OSEL_W2LO: w_opnd = OpW'($signed({1'b0, r_d2[H-1:0]}));
            OSEL_W2HI: w_opnd = OpW'($signed(r_d2[SW-1:H]));
            OSEL_W0LO: w_opnd = OpW'($signed({1'b0, r_w0[H-1:0]}));
            OSEL_W0HI: w_opnd = OpW'($signed(r_w0[SW-1:H]));
            default:   w_opnd = OpW'($signed({1'b0, r_w0[H-1:0]}));
        endcase
    end

    assign w_addend = i_ctl.uw.hi_shift ? (AccW'(r_prod) <<< H) : AccW'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= w_coef * w_opnd;
        if (i_ctl.start) begin
            r_err <= ErrW'(i_setpoint) - ErrW'(i_measured);
        end
        if (i_ctl.run) begin
            case (i_ctl.uw.aop)
                AOP_LOAD_ERR: r_acc <= AccW'(r_err) <<< (2 * F);
                AOP_ADD:      r_acc <= r_acc + w_addend;
                AOP_SUB:      r_acc <= r_acc - w_addend;
                AOP_CLR:      r_acc <= '0;
                default:      r_acc <= r_acc;
            endcase
            if (i_ctl.uw.chk == CHK_W0) begin
                r_w0 <= r_acc[F+SW-1:F];
            end
        end
    end

    assign o_stat.w0_ovf  = (r_acc[AccW-1:F+SW-1] != {(AccW-F-SW+1){r_acc[F+SW-1]}});
    assign o_stat.raw_ovf = (r_acc[AccW-1:2*F+SW-1] != {(AccW-2*F-SW+1){r_acc[2*F+SW-1]}});

    assign w_raw      = r_acc[2*F+SW-1:2*F];
    assign w_lim_hi   = SW'(i_cfg.limit_high);
    assign w_lim_lo   = SW'(i_cfg.limit_low);
    assign w_over_hi  = (w_raw > w_lim_hi);
    assign w_under_lo = !w_over_hi && (w_raw < w_lim_lo);
    assign w_err_pos  = !r_err[ErrW-1] && (r_err != '0);
    assign w_err_neg  = r_err[ErrW-1];
    assign w_freeze   = (w_over_hi && w_err_pos) || (w_under_lo && w_err_neg);

    always_comb begin
        if (w_over_hi) begin
            o_drive = i_cfg.limit_high;
        end else if (w_under_lo) begin
            o_drive = i_cfg.limit_low;
        end else begin
            o_drive = w_raw[LimitW-1:0];
        end
    end
    assign o_clamped = w_over_hi || w_under_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_ctl.commit) begin
            if (i_ctl.uw.fin == FIN_EMIT_CLEAR) begin
                r_d1 <= '0;
                r_d2 <= '0;
            end else if ((i_ctl.uw.fin == FIN_EMIT_RES) && !w_freeze) begin
                r_d2 <= r_d1;
                r_d1 <= r_w0;
            end
        end
    end

    `QPR_ASSERT(a_clear_zeroes, i_clk, i_rst_n, (i_ctl.commit && (i_ctl.uw.fin == FIN_EMIT_CLEAR)) |=> ((r_d1 == '0) && (r_d2 == '0)))
    `QPR_ASSERT(a_state_holds, i_clk, i_rst_n, !i_ctl.commit |=> ($stable(r_d1) && $stable(r_d2)))
    `QPR_ASSERT(a_err_load, i_clk, i_rst_n, (i_ctl.run && (i_ctl.uw.aop == AOP_LOAD_ERR)) |=> (r_acc[2*F-1:0] == '0))

endmodule

// ===== design/quasi_pr_controller_antiwindup.sv =====
`timescale 1ns / 1ps
`include "quasi_pr_controller_antiwindup_assert.svh"

// channel  | dir | payload                         | handshake
// i_in     | in  | req_type, setpoint, measured    | valid / ready
// o_out    | out | drive, clamped, ok              | valid / ready
// apb      | in  | paddr, pwdata -> prdata         | psel / penable, pready tied high
//
// compute sample: the result is registered at the end of the program, which makes ten passes
//   through the one 32 x (STATE_WIDTH - STATE_WIDTH/2 + 1) multiplier and the range checks
// clear request or disabled block: the closing step emits at once; w0 or raw overflow: jump to the fail step
// one sample at a time; a new beat is taken the cycle after the result is registered
// reset (i_rst_n low, synchronous) loads register defaults and zeroes the delay line
// a stalled result holds the last step of the program until o_out.ready

module quasi_pr_controller_antiwindup #(
    parameter int COEF_FRAC_BITS = qpr_pkg::DefCoefFracBits,
    parameter int STATE_WIDTH    = qpr_pkg::DefStateWidth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    qpr_in_if.sink                        i_in,
    qpr_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qpr_pkg::AddrW-1:0]     paddr,
    input  logic [qpr_pkg::DataW-1:0]     pwdata,
    output logic [qpr_pkg::DataW-1:0]     prdata,
    output logic                          pready
);
    import qpr_pkg::*;

    t_cfg                     r_cfg;
    logic                     r_enabled;
    logic                     r_busy, n_busy;
    logic [StepW-1:0]         r_step, n_step;
    logic                     r_out_valid, n_out_valid;
    logic signed [LimitW-1:0] r_drive, n_drive;
    logic                     r_clamped, n_clamped;
    logic                     r_ok, n_ok;

    t_uword                   w_uw;
    t_dp_ctl                  w_ctl;
    t_dp_stat                 w_stat;
    logic signed [LimitW-1:0] w_drive;
    logic                     w_clamped;
    logic                     w_accept, w_emit, w_fire, w_jump, w_apb_wr;
    logic [RegIdxW-1:0]       w_idx;

    // config port
    assign pready   = 1'b1;
    assign w_idx    = paddr[AddrW-1:2];
    assign w_apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.b0         <= '0;
            r_cfg.b1         <= '0;
            r_cfg.b2         <= '0;
            r_cfg.a1         <= '0;
            r_cfg.a2         <= '0;
            r_cfg.limit_low  <= LimitLowReset;
            r_cfg.limit_high <= LimitHighReset;
            r_enabled        <= 1'b0;
        end else if (w_apb_wr) begin
            case (w_idx)
                REG_B0:         r_cfg.b0 <= pwdata;
                REG_B1:         r_cfg.b1 <= pwdata;
                REG_B2:         r_cfg.b2 <= pwdata;
                REG_A1:         r_cfg.a1 <= pwdata;
                REG_A2:         r_cfg.a2 <= pwdata;
                REG_LIMIT_LOW:  r_cfg.limit_low <= pwdata[LimitW-1:0];
                REG_LIMIT_HIGH: r_cfg.limit_high <= pwdata[LimitW-1:0];
                REG_ENABLED:    r_enabled <= pwdata[0];
                default:        r_enabled <= r_enabled;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_B0:         prdata = r_cfg.b0;
            REG_B1:         prdata = r_cfg.b1;
            REG_B2:         prdata = r_cfg.b2;
            REG_A1:         prdata = r_cfg.a1;
            REG_A2:         prdata = r_cfg.a2;
            REG_LIMIT_LOW:  prdata = DataW'(r_cfg.limit_low);
            REG_LIMIT_HIGH: prdata = DataW'(r_cfg.limit_high);
            REG_ENABLED:    prdata = DataW'(r_enabled);
            default:        prdata = '0;
        endcase
    end

    // sequencer
    assign w_uw     = ucode(r_step);
    assign i_in.ready = !r_busy;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_emit   = r_busy && (w_uw.fin != FIN_NONE)
                      && !((w_uw.chk == CHK_RAW) && w_stat.raw_ovf);
    assign w_fire   = w_emit && (!r_out_valid || o_out.ready);
    assign w_jump   = r_busy && (((w_uw.chk == CHK_W0) && w_stat.w0_ovf)
                                 || ((w_uw.chk == CHK_RAW) && w_stat.raw_ovf));

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (w_accept) begin
            n_busy = 1'b1;
            if (i_in.req_type) begin
                n_step = ADDR_CLEAR;
            end else if (!r_enabled) begin
                n_step = ADDR_FAIL;
            end else begin
                n_step = ADDR_START;
            end
        end else if (w_fire) begin
            n_busy = 1'b0;
        end else if (w_jump) begin
            n_step = ADDR_FAIL;
        end else if (r_busy && (w_uw.fin == FIN_NONE)) begin
            n_step = r_step + 1'b1;
        end
    end

    assign w_ctl.run    = r_busy;
    assign w_ctl.start  = w_accept;
    assign w_ctl.commit = w_fire;
    assign w_ctl.uw     = w_uw;

    qpr_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_WIDTH    (STATE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_cfg      (r_cfg),
        .i_setpoint (i_in.setpoint),
        .i_measured (i_in.measured),
        .o_stat     (w_stat),
        .o_drive    (w_drive),
        .o_clamped  (w_clamped)
    );

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        n_drive     = r_drive;
        n_clamped   = r_clamped;
        n_ok        = r_ok;
        if (w_fire) begin
            n_out_valid = 1'b1;
            if (w_uw.fin == FIN_EMIT_RES) begin
                n_drive   = w_drive;
                n_clamped = w_clamped;
                n_ok      = 1'b1;
            end else begin
                n_drive   = '0;
                n_clamped = 1'b0;
                n_ok      = 1'b0;
            end
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ADDR_START;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_drive   <= n_drive;
        r_clamped <= n_clamped;
        r_ok      <= n_ok;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.drive   = r_drive;
    assign o_out.clamped = r_clamped;
    assign o_out.ok      = r_ok;

    `QPR_ASSERT(a_accept_starts, i_clk, i_rst_n, w_accept |=> r_busy)
    `QPR_ASSERT(a_fire_ends, i_clk, i_rst_n, w_fire |=> (!r_busy && r_out_valid))
    `QPR_ASSERT_NEVER(a_stall_only_emit, i_clk, i_rst_n, r_busy && $past(r_busy) && $stable(r_step) && (w_uw.fin == FIN_NONE))

endmodule

// ===== bench/tb_quasi_pr_controller_antiwindup.sv =====
`timescale 1ns / 1ps

module tb_quasi_pr_controller_antiwindup;
    import qpr_pkg::*;

    localparam int FracBits = DefCoefFracBits;
    localparam int StateW   = DefStateWidth;

    typedef struct packed {
        logic signed [LimitW-1:0] drive;
        logic                     clamped;
        logic                     ok;
    } t_drive_res;

    typedef enum int {PH_OFF, PH_STABLE, PH_NOISE, PH_WIDE, PH_SWAPPED} t_phase_kind;

    class t_pr_drive_model;
        logic signed [CoefW-1:0]  b0, b1, b2, a1, a2;
        logic signed [LimitW-1:0] lim_lo, lim_hi;
        logic                     en;
        logic signed [StateW-1:0] w1, w2;
        t_drive_res               expected_drive[$];
        int                       mismatches;

        function new();
            b0 = '0;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            lim_lo = LimitLowReset;
            lim_hi = LimitHighReset;
            en = 1'b0;
            w1 = '0;
            w2 = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [RegIdxW-1:0] idx, logic [DataW-1:0] val);
            case (idx)
                REG_B0:         b0 = val;
                REG_B1:         b1 = val;
                REG_B2:         b2 = val;
                REG_A1:         a1 = val;
                REG_A2:         a2 = val;
                REG_LIMIT_LOW:  lim_lo = val[LimitW-1:0];
                REG_LIMIT_HIGH: lim_hi = val[LimitW-1:0];
                REG_ENABLED:    en = val[0];
                default: ;
            endcase
        endfunction

        function logic signed [127:0] mulw(logic signed [63:0] x, logic signed [63:0] y);
            logic signed [127:0] p, q;
            p = 128'(x);
            q = 128'(y);
            return p * q;
        endfunction

        function bit fits_state(logic signed [127:0] x);
            logic signed [StateW-1:0] t;
            t = x[StateW-1:0];
            return x == t;
        endfunction

        function void take_sample(logic clr, logic signed [SampleW-1:0] sp,
                                  logic signed [SampleW-1:0] ms);
            logic signed [ErrW-1:0]   err;
            logic signed [127:0]      acc, rw;
            logic signed [StateW-1:0] w0, raw;
            t_drive_res               r;
            logic                     hold;
            r = '0;
            hold = 1'b0;
            if (clr) begin
                w1 = '0;
                w2 = '0;
            end else if (en) begin
                err = sp - ms;
                acc = 128'(err);
                acc = acc <<< (2 * FracBits);
                acc = (acc - mulw(64'(a1), 64'(w1)) - mulw(64'(a2), 64'(w2))) >>> FracBits;
                if (fits_state(acc)) begin
                    w0 = acc[StateW-1:0];
                    rw = (mulw(64'(b0), 64'(w0)) + mulw(64'(b1), 64'(w1))
                          + mulw(64'(b2), 64'(w2))) >>> (2 * FracBits);
                    if (fits_state(rw)) begin
                        raw = rw[StateW-1:0];
                        if (raw > lim_hi) begin
                            r.drive = lim_hi;
                            r.clamped = 1'b1;
                            hold = err > 0;
                        end else if (raw < lim_lo) begin
                            r.drive = lim_lo;
                            r.clamped = 1'b1;
                            hold = err < 0;
                        end else begin
                            r.drive = raw[LimitW-1:0];
                        end
                        if (!hold) begin
                            w2 = w1;
                            w1 = w0;
                        end
                        r.ok = 1'b1;
                    end
                end
            end
            expected_drive.push_back(r);
        endfunction

        task flag_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_drive(t_drive_res got);
            t_drive_res exp_r;
            if (expected_drive.size() == 0) begin
                flag_mismatch("result beat with nothing expected");
                return;
            end
            exp_r = expected_drive.pop_front();
            if (got.drive !== exp_r.drive)
                flag_mismatch($sformatf("drive expected %0d got %0d", exp_r.drive, got.drive));
            if (got.clamped !== exp_r.clamped)
                flag_mismatch($sformatf("clamped expected %0b got %0b",
                                        exp_r.clamped, got.clamped));
            if (got.ok !== exp_r.ok)
                flag_mismatch($sformatf("ok expected %0b got %0b", exp_r.ok, got.ok));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;

    qpr_in_if  req_ch ();
    qpr_out_if res_ch ();

    t_pr_drive_model model = new();
    bit              src_idle;
    bit              sink_idle;
    int              hold_req;

    quasi_pr_controller_antiwindup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_drive_res got;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                model.take_sample(req_ch.req_type, req_ch.setpoint, req_ch.measured);
            if (res_ch.valid && res_ch.ready) begin
                got.drive = res_ch.drive;
                got.clamped = res_ch.clamped;
                got.ok = res_ch.ok;
                model.check_drive(got);
            end
        end
    end

    task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic clr, input logic signed [SampleW-1:0] sp,
                               input logic signed [SampleW-1:0] ms);
        int gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= clr;
        req_ch.setpoint <= sp;
        req_ch.measured <= ms;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (model.expected_drive.size() != 0);
    endtask

    task automatic write_all(input int cb0, input int cb1, input int cb2, input int ca1,
                             input int ca2, input int lo, input int hi, input int on);
        apb_write(REG_B0, cb0);
        apb_write(REG_B1, cb1);
        apb_write(REG_B2, cb2);
        apb_write(REG_A1, ca1);
        apb_write(REG_A2, ca2);
        apb_write(REG_LIMIT_LOW, lo);
        apb_write(REG_LIMIT_HIGH, hi);
        apb_write(REG_ENABLED, on);
    endtask

    task automatic load_phase(input t_phase_kind kind);
        int cb0, cb1, cb2, ca1, ca2, lo, hi, mag;
        ca2 = $urandom_range(0, 16609443);
        mag = $urandom_range(0, 16777216 + ca2 - 1);
        ca1 = $urandom_range(0, 1) ? mag : -mag;
        cb0 = $urandom_range(0, 1 << 26) - (1 << 25);
        cb1 = $urandom_range(0, 1 << 26) - (1 << 25);
        cb2 = $urandom_range(0, 1 << 26) - (1 << 25);
        lo = -$urandom_range(100, 20000);
        hi = $urandom_range(100, 20000);
        case (kind)
            PH_NOISE: begin
                cb0 = $urandom;
                cb1 = $urandom;
                cb2 = $urandom;
                ca1 = $urandom;
                ca2 = $urandom;
            end
            PH_WIDE: begin
                cb0 = $urandom;
                cb1 = $urandom;
                cb2 = $urandom;
                lo = -131072;
                hi = 131071;
            end
            PH_SWAPPED: begin
                lo = $urandom_range(0, 5000);
                hi = -$urandom_range(0, 5000);
            end
            default: ;
        endcase
        write_all(cb0, cb1, cb2, ca1, ca2, lo, hi, kind != PH_OFF);
    endtask

    task automatic pick_value(output logic signed [SampleW-1:0] v);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            v = SampleW'($urandom_range(0, 4000) - 2000);
        else if (r < 90)
            v = SampleW'($urandom);
        else
            v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endtask

    initial begin
        int stall;
        res_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                stall = hold_req;
                hold_req = 0;
            end else begin
                stall = sink_idle ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_phase_kind               plan[8];
        logic signed [SampleW-1:0] sp, ms;
        int                        n_items;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.setpoint = '0;
        req_ch.measured = '0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        hold_req = 0;
        plan = '{PH_STABLE, PH_STABLE, PH_NOISE, PH_STABLE, PH_WIDE, PH_OFF, PH_SWAPPED,
                 PH_STABLE};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset
        send_sample(1'b0, 16'sh7fff, 16'sh8000);
        send_sample(1'b1, 16'sh0000, 16'sh0000);
        drain();

        write_all(1 << 24, 1 << 23, -(1 << 22), -(1 << 23), 1 << 22, -131072, 131071, 1);
        send_sample(1'b0, 16'sh7fff, 16'sh8000);
        send_sample(1'b0, 16'sh8000, 16'sh7fff);
        send_sample(1'b0, 16'sh0000, 16'sh0000);
        send_sample(1'b0, -16'sd1, 16'sh0000);
        send_sample(1'b1, 16'sh7fff, 16'sh7fff);
        send_sample(1'b0, 16'sd100, -16'sd100);
        drain();

        // clamping both ways, with and without freeze
        apb_write(REG_LIMIT_LOW, -1000);
        apb_write(REG_LIMIT_HIGH, 1000);
        send_sample(1'b0, 16'sd5000, 16'sd0);
        send_sample(1'b0, 16'sd5000, 16'sd0);
        send_sample(1'b0, -16'sd10, 16'sd0);
        send_sample(1'b0, -16'sd5000, 16'sd0);
        send_sample(1'b0, -16'sd5000, 16'sd0);
        send_sample(1'b0, 16'sd10, 16'sd0);
        drain();

        // limits out of order
        apb_write(REG_LIMIT_LOW, 500);
        apb_write(REG_LIMIT_HIGH, -500);
        send_sample(1'b1, 16'sd0, 16'sd0);
        send_sample(1'b0, 16'sd0, 16'sd0);
        send_sample(1'b0, -16'sd3000, 16'sd0);
        drain();

        // widest limits, largest gain
        write_all(32'h7fff_ffff, 0, 0, 0, 0, -131072, 131071, 1);
        send_sample(1'b0, 16'sh7fff, 16'sh8000);
        send_sample(1'b0, 16'sh8000, 16'sh7fff);
        drain();

        // state overflow
        write_all(0, 0, 0, 32'h8000_0000, 0, -131072, 131071, 1);
        send_sample(1'b1, 16'sd0, 16'sd0);
        send_sample(1'b0, 16'sh7fff, 16'sh8000);
        send_sample(1'b0, 16'sh7fff, 16'sh8000);
        send_sample(1'b0, 16'sh7fff, 16'sh8000);
        drain();

        // clear while disabled
        apb_write(REG_ENABLED, 0);
        send_sample(1'b1, 16'sd0, 16'sd0);
        drain();

        for (int p = 0; p < 8; p++) begin
            load_phase(plan[p]);
            src_idle = (p % 3) != 1;
            sink_idle = (p % 3) != 2;
            n_items = (plan[p] == PH_OFF) ? 40 : 190;
            for (int k = 0; k < n_items; k++) begin
                if (p == 1 && k == 60) hold_req = 90;
                if (p == 3 && k == 100) drain();
                pick_value(sp);
                pick_value(ms);
                send_sample($urandom_range(0, 99) < 6, sp, ms);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (model.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== quasi_pr_controller_antiwindup.f =====
+incdir+design
design/qpr_pkg.sv
design/qpr_in_if.sv
design/qpr_out_if.sv
design/qpr_datapath.sv
design/quasi_pr_controller_antiwindup.sv
bench/tb_quasi_pr_controller_antiwindup.sv
